// ===== hdl/wfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word frequency counter package
// Sizes, codes and item types shared by the counter core and its comparator.
// ----------------------------------------------------------------------------
package wfc_pkg;

  localparam int unsigned CHUNKS      = 8;
  localparam int unsigned CH_W        = 3;
  localparam int unsigned CHUNK_BYTES = 8;
  localparam int unsigned CHUNK_W     = 64;
  localparam int unsigned TEXT_W      = CHUNKS * CHUNK_W;
  localparam int unsigned WORD_BYTES  = 64;
  localparam int unsigned MAX_LEN     = WORD_BYTES - 1;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned WORD_SLOTS  = 1024;
  localparam int unsigned WIDX_W      = 10;
  localparam int unsigned WCNT_W      = 11;
  localparam int unsigned STOP_SLOTS  = 256;
  localparam int unsigned SIDX_W      = 8;
  localparam int unsigned SCNT_W      = 9;
  localparam int unsigned TOP_K       = 20;
  localparam int unsigned RANK_W      = 5;
  localparam int unsigned TALLY_W     = 32;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef enum logic [1:0] {
    KIND_STOP   = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REC_TOTALS = 2'd0,
    REC_RANK   = 2'd1,
    REC_CHUNK  = 2'd2
  } rec_e;

  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } cmp_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_req;
    logic [9:0]  slot;
    logic [2:0]  chunk;
  } req_t;

  typedef struct packed {
    rec_e        record_type;
    logic [31:0] total_words;
    logic [10:0] unique_words;
    logic [4:0]  rank;
    logic [9:0]  entry_index;
    logic [31:0] count;
    logic [63:0] word_chars;
    logic [5:0]  word_length;
    logic        last;
  } res_t;

endpackage

// ===== hdl/word_frequency_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word frequency counter core
// Stopword filtering, word table counting, top list ranking and chunk reads.
// Stopword byte: taken in idle; a line end commits, storing a kept line chunk by chunk.
// Letter: appended in dispatch. Word end: stopword scan; on a miss, word table scan, then new entry.
// Finish: totals after word end; each ranked item rescans every table entry.
// Chunk read: slot read, none for an unused slot. One item at a time; table scans set the rate.
// Results are strobed for one cycle and cannot be stalled.
// Reset clears counters and the open word and line; tables stay unwritten.
// ----------------------------------------------------------------------------
module word_frequency_counter_core import wfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic res_valid_o,
  output res_t res_o
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_COMMIT   = 13'b0000000000010,
    S_DISPATCH = 13'b0000000000100,
    S_STOP_RD  = 13'b0000000001000,
    S_STOP_CMP = 13'b0000000010000,
    S_WORD_RD  = 13'b0000000100000,
    S_WORD_CMP = 13'b0000001000000,
    S_WORD_NEW = 13'b0000010000000,
    S_REPORT   = 13'b0000100000000,
    S_RK_RD    = 13'b0001000000000,
    S_RK_TAL   = 13'b0010000000000,
    S_RK_TXT   = 13'b0100000000000,
    S_READ_OUT = 13'b1000000000000
  } state_e;

  // memories
  logic [CHUNK_W-1:0] stop_text_mem [STOP_SLOTS*CHUNKS];
  logic [LEN_W-1:0]   stop_len_mem  [STOP_SLOTS];
  logic [CHUNK_W-1:0] word_text_mem [WORD_SLOTS*CHUNKS];
  logic [LEN_W-1:0]   word_len_mem  [WORD_SLOTS];
  logic [TALLY_W-1:0] word_tally_mem[WORD_SLOTS];

  logic                     st_we;
  logic [SIDX_W+CH_W-1:0]   st_waddr, st_raddr;
  logic [CHUNK_W-1:0]       st_wdata, st_rdata_q;
  logic                     sl_we;
  logic [SIDX_W-1:0]        sl_waddr, sl_raddr;
  logic [LEN_W-1:0]         sl_wdata, sl_rdata_q;
  logic                     wt_we;
  logic [WIDX_W+CH_W-1:0]   wt_waddr, wt_raddr;
  logic [CHUNK_W-1:0]       wt_wdata, wt_rdata_q;
  logic                     wl_we;
  logic [WIDX_W-1:0]        wl_waddr, wl_raddr;
  logic [LEN_W-1:0]         wl_wdata, wl_rdata_q;
  logic                     wy_we;
  logic [WIDX_W-1:0]        wy_waddr, wy_raddr;
  logic [TALLY_W-1:0]       wy_wdata, wy_rdata_q;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stop_text_mem[st_waddr] <= st_wdata;
    end
    st_rdata_q <= stop_text_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sl_we) begin
      stop_len_mem[sl_waddr] <= sl_wdata;
    end
    sl_rdata_q <= stop_len_mem[sl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      word_text_mem[wt_waddr] <= wt_wdata;
    end
    wt_rdata_q <= word_text_mem[wt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wl_we) begin
      word_len_mem[wl_waddr] <= wl_wdata;
    end
    wl_rdata_q <= word_len_mem[wl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wy_we) begin
      word_tally_mem[wy_waddr] <= wy_wdata;
    end
    wy_rdata_q <= word_tally_mem[wy_raddr];
  end

  // control state
  state_e             state_q, state_d;
  req_t               req_q, req_d;
  logic [TEXT_W-1:0]  pend_q, pend_d;
  logic [LEN_W-1:0]   pend_len_q, pend_len_d;
  logic [LEN_W-1:0]   pend_kept_q, pend_kept_d;
  logic               skip_q, skip_d;
  logic [SCNT_W-1:0]  stop_used_q, stop_used_d;
  logic [TEXT_W-1:0]  tok_q, tok_d;
  logic [LEN_W-1:0]   tok_len_q, tok_len_d;
  logic [WCNT_W-1:0]  entries_q, entries_d;
  logic [TALLY_W-1:0] total_q, total_d;
  logic [WCNT_W-1:0]  idx_q, idx_d;
  logic [CH_W-1:0]    c_q, c_d;
  logic [RANK_W-1:0]  r_q, r_d;
  logic [RANK_W-1:0]  n_q, n_d;
  logic               found_q, found_d;
  logic               res_valid_q, res_valid_d;

  // ranking payload
  logic [TALLY_W-1:0] prev_tally_q, prev_tally_d;
  logic [TEXT_W-1:0]  prev_text_q, prev_text_d;
  logic [WIDX_W-1:0]  best_idx_q, best_idx_d;
  logic [TALLY_W-1:0] best_tally_q, best_tally_d;
  logic [LEN_W-1:0]   best_len_q, best_len_d;
  logic [TEXT_W-1:0]  best_text_q, best_text_d;
  logic [TEXT_W-1:0]  cand_text_q, cand_text_d;
  logic [TALLY_W-1:0] cand_tally_q, cand_tally_d;
  logic [LEN_W-1:0]   cand_len_q, cand_len_d;
  cmp_e               prev_rel_q, prev_rel_d;
  cmp_e               best_rel_q, best_rel_d;
  res_t               res_q, res_d;

  logic [CHUNK_W-1:0] tok_chunk, pend_chunk, prev_chunk, best_chunk;
  logic [LEN_W-1:0]   tok_len_m1;
  logic [CH_W-1:0]    tok_last_c;
  cmp_e               rel_prev, rel_best;

  assign tok_chunk  = tok_q[{c_q, 6'b0} +: CHUNK_W];
  assign pend_chunk = pend_q[{c_q, 6'b0} +: CHUNK_W];
  assign prev_chunk = prev_text_q[{c_q, 6'b0} +: CHUNK_W];
  assign best_chunk = best_text_q[{c_q, 6'b0} +: CHUNK_W];
  assign tok_len_m1 = tok_len_q - LEN_W'(1);
  assign tok_last_c = tok_len_m1[LEN_W-1:3];

  wfc_lexcmp u_cmp_prev (
    .a_i  (prev_chunk),
    .b_i  (wt_rdata_q),
    .rel_o(rel_prev)
  );

  wfc_lexcmp u_cmp_best (
    .a_i  (wt_rdata_q),
    .b_i  (best_chunk),
    .rel_o(rel_best)
  );

  always_comb begin
    logic               skip_v;
    logic [7:0]         ch;
    logic               upper, lower;
    logic               commit_done;
    logic               word_done;
    logic               prev_ok, choose;
    cmp_e               prev_rel_n, best_rel_n;
    logic [CHUNK_W-1:0] masked;

    state_d      = state_q;
    req_d        = req_q;
    pend_d       = pend_q;
    pend_len_d   = pend_len_q;
    pend_kept_d  = pend_kept_q;
    skip_d       = skip_q;
    stop_used_d  = stop_used_q;
    tok_d        = tok_q;
    tok_len_d    = tok_len_q;
    entries_d    = entries_q;
    total_d      = total_q;
    idx_d        = idx_q;
    c_d          = c_q;
    r_d          = r_q;
    n_d          = n_q;
    found_d      = found_q;
    prev_tally_d = prev_tally_q;
    prev_text_d  = prev_text_q;
    best_idx_d   = best_idx_q;
    best_tally_d = best_tally_q;
    best_len_d   = best_len_q;
    best_text_d  = best_text_q;
    cand_text_d  = cand_text_q;
    cand_tally_d = cand_tally_q;
    cand_len_d   = cand_len_q;
    prev_rel_d   = prev_rel_q;
    best_rel_d   = best_rel_q;
    res_d        = '0;
    res_valid_d  = 1'b0;

    st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
    sl_we = 1'b0; sl_waddr = '0; sl_wdata = '0; sl_raddr = '0;
    wt_we = 1'b0; wt_waddr = '0; wt_wdata = '0; wt_raddr = '0;
    wl_we = 1'b0; wl_waddr = '0; wl_wdata = '0; wl_raddr = '0;
    wy_we = 1'b0; wy_waddr = '0; wy_wdata = '0; wy_raddr = '0;

    ch          = req_q.byte_req;
    upper       = (ch >= 8'h41) && (ch <= 8'h5A);
    lower       = (ch >= 8'h61) && (ch <= 8'h7A);
    skip_v      = 1'b0;
    commit_done = 1'b0;
    word_done   = 1'b0;
    prev_ok     = 1'b0;
    choose      = 1'b0;
    prev_rel_n  = (prev_rel_q == CMP_EQ) ? rel_prev : prev_rel_q;
    best_rel_n  = (best_rel_q == CMP_EQ) ? rel_best : best_rel_q;
    for (int j = 0; j < CHUNK_BYTES; j++) begin
      masked[8*j +: 8] = ({c_q, 3'(j)} < pend_kept_q) ? pend_chunk[8*j +: 8] : 8'h00;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.kind == KIND_STOP) begin
            if (req_i.byte_req == CHAR_LF) begin
              state_d = S_COMMIT;
            end else begin
              skip_v = skip_q | (req_i.byte_req == CHAR_CR);
              skip_d = skip_v;
              if (!skip_v) begin
                pend_d[{pend_len_q, 3'b0} +: 8] = req_i.byte_req;
                if ((pend_kept_q == pend_len_q) && (req_i.byte_req != 8'h00)) begin
                  pend_kept_d = pend_kept_q + LEN_W'(1);
                end
              end
              pend_len_d = pend_len_q + LEN_W'(1);
              if (pend_len_d >= LEN_W'(MAX_LEN)) begin
                state_d = S_COMMIT;
              end
            end
          end else if (pend_len_q != '0) begin
            state_d = S_COMMIT;
          end else begin
            state_d = S_DISPATCH;
          end
        end
      end

      S_COMMIT: begin
        if ((pend_kept_q != '0) && (stop_used_q < SCNT_W'(STOP_SLOTS))) begin
          st_we    = 1'b1;
          st_waddr = {stop_used_q[SIDX_W-1:0], c_q};
          st_wdata = masked;
          if (c_q == '0) begin
            sl_we    = 1'b1;
            sl_waddr = stop_used_q[SIDX_W-1:0];
            sl_wdata = pend_kept_q;
          end
          c_d = c_q + CH_W'(1);
          if (c_q == CH_W'(CHUNKS - 1)) begin
            stop_used_d = stop_used_q + SCNT_W'(1);
            commit_done = 1'b1;
          end
        end else begin
          commit_done = 1'b1;
        end
        if (commit_done) begin
          pend_d      = '0;
          pend_len_d  = '0;
          pend_kept_d = '0;
          skip_d      = 1'b0;
          state_d     = (req_q.kind == KIND_STOP) ? S_IDLE : S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (req_q.kind)
          KIND_TEXT: begin
            if (upper || lower) begin
              if (tok_len_q < LEN_W'(MAX_LEN)) begin
                tok_d[{tok_len_q, 3'b0} +: 8] = ch | CASE_BIT;
                tok_len_d = tok_len_q + LEN_W'(1);
              end
              state_d = S_IDLE;
            end else if (tok_len_q == '0) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = '0;
              state_d = S_STOP_RD;
            end
          end
          KIND_FINISH: begin
            if (tok_len_q != '0) begin
              idx_d   = '0;
              state_d = S_STOP_RD;
            end else begin
              state_d = S_REPORT;
            end
          end
          KIND_READ: begin
            if ({1'b0, req_q.slot} < entries_q) begin
              wt_raddr = {req_q.slot, req_q.chunk};
              wl_raddr = req_q.slot;
              wy_raddr = req_q.slot;
              state_d  = S_READ_OUT;
            end else begin
              res_valid_d       = 1'b1;
              res_d.record_type = REC_CHUNK;
              res_d.entry_index = req_q.slot;
              res_d.last        = 1'b1;
              state_d           = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_STOP_RD: begin
        if (idx_q < {2'b0, stop_used_q}) begin
          sl_raddr = idx_q[SIDX_W-1:0];
          st_raddr = {idx_q[SIDX_W-1:0], CH_W'(0)};
          state_d  = S_STOP_CMP;
        end else begin
          idx_d   = '0;
          state_d = S_WORD_RD;
        end
      end

      S_STOP_CMP: begin
        if (((c_q == '0) && (sl_rdata_q != tok_len_q)) || (st_rdata_q != tok_chunk)) begin
          c_d     = '0;
          idx_d   = idx_q + WCNT_W'(1);
          state_d = S_STOP_RD;
        end else if (c_q == tok_last_c) begin
          c_d       = '0;
          word_done = 1'b1;
        end else begin
          c_d      = c_q + CH_W'(1);
          st_raddr = {idx_q[SIDX_W-1:0], c_d};
        end
      end

      S_WORD_RD: begin
        if (idx_q < entries_q) begin
          wl_raddr = idx_q[WIDX_W-1:0];
          wy_raddr = idx_q[WIDX_W-1:0];
          wt_raddr = {idx_q[WIDX_W-1:0], CH_W'(0)};
          state_d  = S_WORD_CMP;
        end else if (entries_q < WCNT_W'(WORD_SLOTS)) begin
          c_d     = '0;
          state_d = S_WORD_NEW;
        end else begin
          word_done = 1'b1;
        end
      end

      S_WORD_CMP: begin
        wy_raddr = idx_q[WIDX_W-1:0];
        if (((c_q == '0) && (wl_rdata_q != tok_len_q)) || (wt_rdata_q != tok_chunk)) begin
          c_d     = '0;
          idx_d   = idx_q + WCNT_W'(1);
          state_d = S_WORD_RD;
        end else if (c_q == tok_last_c) begin
          c_d      = '0;
          wy_we    = 1'b1;
          wy_waddr = idx_q[WIDX_W-1:0];
          wy_wdata = (wy_rdata_q == '1) ? wy_rdata_q : wy_rdata_q + TALLY_W'(1);
          if (total_q != '1) begin
            total_d = total_q + TALLY_W'(1);
          end
          word_done = 1'b1;
        end else begin
          c_d      = c_q + CH_W'(1);
          wt_raddr = {idx_q[WIDX_W-1:0], c_d};
        end
      end

      S_WORD_NEW: begin
        wt_we    = 1'b1;
        wt_waddr = {entries_q[WIDX_W-1:0], c_q};
        wt_wdata = tok_chunk;
        if (c_q == '0) begin
          wl_we    = 1'b1;
          wl_waddr = entries_q[WIDX_W-1:0];
          wl_wdata = tok_len_q;
          wy_we    = 1'b1;
          wy_waddr = entries_q[WIDX_W-1:0];
          wy_wdata = TALLY_W'(1);
        end
        c_d = c_q + CH_W'(1);
        if (c_q == CH_W'(CHUNKS - 1)) begin
          entries_d = entries_q + WCNT_W'(1);
          if (total_q != '1) begin
            total_d = total_q + TALLY_W'(1);
          end
          word_done = 1'b1;
        end
      end

      S_REPORT: begin
        res_valid_d        = 1'b1;
        res_d.record_type  = REC_TOTALS;
        res_d.total_words  = total_q;
        res_d.unique_words = entries_q;
        res_d.last         = (entries_q == '0);
        n_d = (entries_q < WCNT_W'(TOP_K)) ? entries_q[RANK_W-1:0] : RANK_W'(TOP_K);
        r_d     = '0;
        idx_d   = '0;
        found_d = 1'b0;
        state_d = (entries_q == '0) ? S_IDLE : S_RK_RD;
      end

      S_RK_RD: begin
        if (idx_q < entries_q) begin
          wy_raddr = idx_q[WIDX_W-1:0];
          wl_raddr = idx_q[WIDX_W-1:0];
          state_d  = S_RK_TAL;
        end else begin
          res_valid_d       = 1'b1;
          res_d.record_type = REC_RANK;
          res_d.rank        = r_q;
          res_d.entry_index = best_idx_q;
          res_d.count       = best_tally_q;
          res_d.word_chars  = best_text_q[CHUNK_W-1:0];
          res_d.word_length = best_len_q;
          res_d.last        = (r_q + RANK_W'(1) == n_q);
          prev_tally_d      = best_tally_q;
          prev_text_d       = best_text_q;
          if (r_q + RANK_W'(1) == n_q) begin
            state_d = S_IDLE;
          end else begin
            r_d     = r_q + RANK_W'(1);
            idx_d   = '0;
            found_d = 1'b0;
          end
        end
      end

      S_RK_TAL: begin
        if (((r_q != '0) && (prev_tally_q < wy_rdata_q)) ||
            (found_q && (wy_rdata_q < best_tally_q))) begin
          idx_d   = idx_q + WCNT_W'(1);
          state_d = S_RK_RD;
        end else begin
          cand_tally_d = wy_rdata_q;
          cand_len_d   = wl_rdata_q;
          prev_rel_d   = CMP_EQ;
          best_rel_d   = CMP_EQ;
          c_d          = '0;
          wt_raddr     = {idx_q[WIDX_W-1:0], CH_W'(0)};
          state_d      = S_RK_TXT;
        end
      end

      S_RK_TXT: begin
        cand_text_d[{c_q, 6'b0} +: CHUNK_W] = wt_rdata_q;
        prev_rel_d = prev_rel_n;
        best_rel_d = best_rel_n;
        if (c_q != CH_W'(CHUNKS - 1)) begin
          c_d      = c_q + CH_W'(1);
          wt_raddr = {idx_q[WIDX_W-1:0], c_d};
        end else begin
          c_d     = '0;
          prev_ok = (r_q == '0) || (prev_tally_q > cand_tally_q) ||
                    ((prev_tally_q == cand_tally_q) && (prev_rel_n == CMP_LT));
          choose  = !found_q || (cand_tally_q > best_tally_q) ||
                    ((cand_tally_q == best_tally_q) && (best_rel_n == CMP_LT));
          if (prev_ok && choose) begin
            found_d      = 1'b1;
            best_idx_d   = idx_q[WIDX_W-1:0];
            best_tally_d = cand_tally_q;
            best_len_d   = cand_len_q;
            best_text_d  = cand_text_d;
          end
          idx_d   = idx_q + WCNT_W'(1);
          state_d = S_RK_RD;
        end
      end

      S_READ_OUT: begin
        res_valid_d       = 1'b1;
        res_d.record_type = REC_CHUNK;
        res_d.entry_index = req_q.slot;
        res_d.count       = wy_rdata_q;
        res_d.word_chars  = wt_rdata_q;
        res_d.word_length = wl_rdata_q;
        res_d.last        = 1'b1;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (word_done) begin
      tok_d     = '0;
      tok_len_d = '0;
      state_d   = (req_q.kind == KIND_FINISH) ? S_REPORT : S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= '0;
      pend_len_q  <= '0;
      pend_kept_q <= '0;
      skip_q      <= 1'b0;
      stop_used_q <= '0;
      tok_q       <= '0;
      tok_len_q   <= '0;
      entries_q   <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      c_q         <= '0;
      r_q         <= '0;
      n_q         <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      pend_len_q  <= pend_len_d;
      pend_kept_q <= pend_kept_d;
      skip_q      <= skip_d;
      stop_used_q <= stop_used_d;
      tok_q       <= tok_d;
      tok_len_q   <= tok_len_d;
      entries_q   <= entries_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      c_q         <= c_d;
      r_q         <= r_d;
      n_q         <= n_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    prev_tally_q <= prev_tally_d;
    prev_text_q  <= prev_text_d;
    best_idx_q   <= best_idx_d;
    best_tally_q <= best_tally_d;
    best_len_q   <= best_len_d;
    best_text_q  <= best_text_d;
    cand_text_q  <= cand_text_d;
    cand_tally_q <= cand_tally_d;
    cand_len_q   <= cand_len_d;
    prev_rel_q   <= prev_rel_d;
    best_rel_q   <= best_rel_d;
    res_q        <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/wfc_lexcmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk string comparator
// Orders two eight-character chunks as byte strings, first character first.
// ----------------------------------------------------------------------------
module wfc_lexcmp import wfc_pkg::*; (
  input  logic [CHUNK_W-1:0] a_i,
  input  logic [CHUNK_W-1:0] b_i,
  output cmp_e               rel_o
);

  logic [CHUNK_W-1:0] a_sw;
  logic [CHUNK_W-1:0] b_sw;

  always_comb begin
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      a_sw[8*(CHUNK_BYTES-1-k) +: 8] = a_i[8*k +: 8];
      b_sw[8*(CHUNK_BYTES-1-k) +: 8] = b_i[8*k +: 8];
    end
    if (a_sw < b_sw) begin
      rel_o = CMP_LT;
    end else if (a_sw > b_sw) begin
      rel_o = CMP_GT;
    end else begin
      rel_o = CMP_EQ;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word frequency counter core testbench
// Drives stopword lines, text, finish and chunk-read items with random gaps,
// predicts records with a local table model or takes them from typed rows, and checks each field.
// ----------------------------------------------------------------------------
module tb_top;
  import wfc_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 60000;
  localparam int unsigned RANDOM_ITEMS    = 480;
  localparam int unsigned QUIET_ITEMS     = 80;

  typedef struct {
    req_t req;
    bit   typed;
    res_t rec;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  word_frequency_counter_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // counter model state
  bit [TEXT_W-1:0]  stop_txt [STOP_SLOTS];
  int unsigned      stop_len [STOP_SLOTS];
  int unsigned      stop_cnt;
  bit [TEXT_W-1:0]  line_txt;
  int unsigned      line_len;
  bit               line_skip;
  bit [TEXT_W-1:0]  word_txt [WORD_SLOTS];
  int unsigned      word_len [WORD_SLOTS];
  bit [31:0]        word_tal [WORD_SLOTS];
  int unsigned      entry_cnt;
  bit [31:0]        total_cnt;
  bit [TEXT_W-1:0]  tok_txt;
  int unsigned      tok_len;
  int unsigned      ranked [TOP_K];

  res_t        expected_records[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void commit_line();
    int unsigned kept;
    bit [TEXT_W-1:0] t;
    kept = 0;
    t = '0;
    while (kept < line_len && line_txt[kept*8 +: 8] != 8'h00) begin
      t[kept*8 +: 8] = line_txt[kept*8 +: 8];
      kept++;
    end
    if (kept > 0 && stop_cnt < STOP_SLOTS) begin
      stop_txt[stop_cnt] = t;
      stop_len[stop_cnt] = kept;
      stop_cnt++;
    end
    line_txt  = '0;
    line_len  = 0;
    line_skip = 1'b0;
  endfunction

  function automatic void end_word();
    bit hit;
    bit counted;
    if (tok_len == 0) return;
    hit = 1'b0;
    for (int i = 0; i < stop_cnt; i++)
      if (stop_len[i] == tok_len && stop_txt[i] == tok_txt) hit = 1'b1;
    if (!hit) begin
      counted = 1'b0;
      for (int i = 0; i < entry_cnt; i++) begin
        if (!counted && word_txt[i] == tok_txt) begin
          if (word_tal[i] != 32'hFFFF_FFFF) word_tal[i]++;
          counted = 1'b1;
        end
      end
      if (!counted && entry_cnt < WORD_SLOTS) begin
        word_txt[entry_cnt] = tok_txt;
        word_len[entry_cnt] = tok_len;
        word_tal[entry_cnt] = 32'd1;
        entry_cnt++;
        counted = 1'b1;
      end
      if (counted && total_cnt != 32'hFFFF_FFFF) total_cnt++;
    end
    tok_txt = '0;
    tok_len = 0;
  endfunction

  function automatic bit ahead_of(int unsigned a, int unsigned b);
    if (word_tal[a] != word_tal[b]) return word_tal[a] > word_tal[b];
    for (int i = 0; i < WORD_BYTES; i++)
      if (word_txt[a][i*8 +: 8] != word_txt[b][i*8 +: 8])
        return word_txt[a][i*8 +: 8] < word_txt[b][i*8 +: 8];
    return 1'b0;
  endfunction

  // applies one accepted item and queues the records it causes
  function automatic void count_item(req_t r, bit queue_records);
    res_t rec;
    int unsigned n;
    int unsigned best;
    bit found;
    logic [7:0] b;
    b = r.byte_req;
    if (r.kind == KIND_STOP) begin
      if (b == CHAR_LF) begin
        commit_line();
      end else begin
        if (b == CHAR_CR) line_skip = 1'b1;
        if (!line_skip) line_txt[line_len*8 +: 8] = b;
        line_len++;
        if (line_len >= MAX_LEN) commit_line();
      end
      return;
    end
    if (line_len > 0) commit_line();
    if (r.kind == KIND_TEXT) begin
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
        if (tok_len < MAX_LEN) begin
          tok_txt[tok_len*8 +: 8] = (b <= "Z") ? (b | CASE_BIT) : b;
          tok_len++;
        end
      end else begin
        end_word();
      end
      return;
    end
    rec = '0;
    if (r.kind == KIND_FINISH) begin
      end_word();
      n = (entry_cnt < TOP_K) ? entry_cnt : TOP_K;
      rec.record_type  = REC_TOTALS;
      rec.total_words  = total_cnt;
      rec.unique_words = WCNT_W'(entry_cnt);
      rec.last         = (n == 0);
      if (queue_records) expected_records.push_back(rec);
      for (int k = 0; k < n; k++) begin
        found = 1'b0;
        best  = 0;
        for (int e = 0; e < entry_cnt; e++) begin
          if (k > 0 && !ahead_of(ranked[k-1], e)) continue;
          if (!found || ahead_of(e, best)) begin
            best  = e;
            found = 1'b1;
          end
        end
        ranked[k] = best;
        rec = '0;
        rec.record_type = REC_RANK;
        rec.rank        = RANK_W'(k);
        rec.entry_index = WIDX_W'(best);
        rec.count       = word_tal[best];
        rec.word_chars  = word_txt[best][63:0];
        rec.word_length = LEN_W'(word_len[best]);
        rec.last        = (k + 1 == n);
        if (queue_records) expected_records.push_back(rec);
      end
      return;
    end
    rec.record_type = REC_CHUNK;
    rec.entry_index = r.slot;
    rec.last        = 1'b1;
    if (r.slot < entry_cnt) begin
      rec.count       = word_tal[r.slot];
      rec.word_chars  = word_txt[r.slot][r.chunk*64 +: 64];
      rec.word_length = LEN_W'(word_len[r.slot]);
    end
    if (queue_records) expected_records.push_back(rec);
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got %0h expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_records.size() == 0) begin
        $display("%0t: record with nothing expected (type %0d)", $realtime,
                 res_o.record_type);
        errors++;
      end else begin
        e = expected_records.pop_front();
        if (res_o.record_type != e.record_type)
          report_mismatch("record_type", 64'(res_o.record_type), 64'(e.record_type));
        if (res_o.total_words != e.total_words)
          report_mismatch("total_words", 64'(res_o.total_words), 64'(e.total_words));
        if (res_o.unique_words != e.unique_words)
          report_mismatch("unique_words", 64'(res_o.unique_words), 64'(e.unique_words));
        if (res_o.rank != e.rank) report_mismatch("rank", 64'(res_o.rank), 64'(e.rank));
        if (res_o.entry_index != e.entry_index)
          report_mismatch("entry_index", 64'(res_o.entry_index), 64'(e.entry_index));
        if (res_o.count != e.count)
          report_mismatch("count", 64'(res_o.count), 64'(e.count));
        if (res_o.word_chars != e.word_chars)
          report_mismatch("word_chars", res_o.word_chars, e.word_chars);
        if (res_o.word_length != e.word_length)
          report_mismatch("word_length", 64'(res_o.word_length), 64'(e.word_length));
        if (res_o.last != e.last) report_mismatch("last", 64'(res_o.last), 64'(e.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || res_valid_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_CYCLES);
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic pause();
    int unsigned n;
    if (quiet || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 11);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send(req_t r, bit typed = 1'b0, res_t rec = '0);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    count_item(r, !typed);
    if (typed) expected_records.push_back(rec);
    items_sent++;
    pause();
  endtask

  function automatic req_t mk(kind_e k, logic [7:0] b = 8'h00, logic [9:0] s = '0,
                              logic [2:0] c = '0);
    req_t r;
    r.kind     = k;
    r.byte_req = b;
    r.slot     = s;
    r.chunk    = c;
    return r;
  endfunction

  function automatic logic [7:0] separator();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"));
    return b;
  endfunction

  task automatic send_word(string w, kind_e k);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if ($urandom_range(0, 3) == 0 && c >= "a" && c <= "z") c = c & ~CASE_BIT;
      send(mk(k, c));
    end
  endtask

  string vocab[] = '{"the", "of", "and", "data", "word", "count", "a", "an", "is",
                     "zebra", "zeb", "apple", "x", "queue", "table", "stop"};

  row_t rows[$];
  res_t typed_rec;

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    errors = 0;
    items_sent = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    stop_cnt = 0; line_txt = '0; line_len = 0; line_skip = 1'b0;
    entry_cnt = 0; total_cnt = 0; tok_txt = '0; tok_len = 0;

    typed_rec = '0;
    typed_rec.record_type = REC_TOTALS;
    typed_rec.last = 1'b1;
    rows.push_back('{mk(KIND_FINISH), 1'b1, typed_rec});
    typed_rec = '0;
    typed_rec.record_type = REC_CHUNK;
    typed_rec.entry_index = 10'h3FF;
    typed_rec.last = 1'b1;
    rows.push_back('{mk(KIND_READ, 8'hFF, 10'h3FF, 3'd7), 1'b1, typed_rec});
    rows.push_back('{mk(KIND_STOP, "t"), 1'b0, '0});
    rows.push_back('{mk(KIND_STOP, "h"), 1'b0, '0});
    rows.push_back('{mk(KIND_STOP, "e"), 1'b0, '0});
    rows.push_back('{mk(KIND_STOP, CHAR_LF), 1'b0, '0});
    // upper case stopword with trailing junk after CR
    rows.push_back('{mk(KIND_STOP, "A"), 1'b0, '0});
    rows.push_back('{mk(KIND_STOP, CHAR_CR), 1'b0, '0});
    rows.push_back('{mk(KIND_STOP, "x"), 1'b0, '0});
    rows.push_back('{mk(KIND_STOP, CHAR_LF), 1'b0, '0});
    // NUL-only line left pending, committed by the next text item
    rows.push_back('{mk(KIND_STOP, 8'h00), 1'b0, '0});
    rows.push_back('{mk(KIND_TEXT, "T"), 1'b0, '0});
    rows.push_back('{mk(KIND_TEXT, "h"), 1'b0, '0});
    rows.push_back('{mk(KIND_TEXT, "E"), 1'b0, '0});
    rows.push_back('{mk(KIND_TEXT, 8'hFF), 1'b0, '0});
    rows.push_back('{mk(KIND_TEXT, "Z"), 1'b0, '0});
    rows.push_back('{mk(KIND_TEXT, "z"), 1'b0, '0});
    rows.push_back('{mk(KIND_TEXT, "@"), 1'b0, '0});
    rows.push_back('{mk(KIND_TEXT, "a"), 1'b0, '0});
    rows.push_back('{mk(KIND_FINISH), 1'b0, '0});
    rows.push_back('{mk(KIND_READ, 8'h00, 10'd0, 3'd0), 1'b0, '0});
    typed_rec.entry_index = 10'd5;
    rows.push_back('{mk(KIND_READ, 8'h00, 10'd5, 3'd3), 1'b1, typed_rec});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].rec);

    while (items_sent < RANDOM_ITEMS) begin
      int unsigned pick;
      quiet = (items_sent + QUIET_ITEMS > RANDOM_ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_word(vocab[$urandom_range(0, vocab.size() - 1)], KIND_STOP);
        if ($urandom_range(0, 2) == 0) send(mk(KIND_STOP, CHAR_CR));
        send(mk(KIND_STOP, CHAR_LF));
      end else if (pick < 5) begin
        repeat ($urandom_range(64, 70)) send(mk(KIND_STOP, 8'($urandom_range(0, 255))));
      end else if (pick < 6) begin
        repeat ($urandom_range(60, 70)) send(mk(KIND_TEXT, "q"));
        send(mk(KIND_TEXT, separator()));
      end else if (pick < 72) begin
        send_word(vocab[$urandom_range(0, vocab.size() - 1)], KIND_TEXT);
        send(mk(KIND_TEXT, separator()));
      end else if (pick < 84) begin
        send(mk(KIND_TEXT, 8'($urandom_range(0, 255))));
      end else if (pick < 90) begin
        send(mk(KIND_FINISH, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                3'($urandom_range(0, 7))));
      end else if (pick < 97) begin
        send(mk(KIND_READ, 8'($urandom_range(0, 255)),
                10'($urandom_range(0, entry_cnt + 1)), 3'($urandom_range(0, 7))));
      end else begin
        send(mk(KIND_READ, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                3'($urandom_range(0, 7))));
      end
    end
    send(mk(KIND_FINISH));
    start <= 1'b0;

    while (expected_records.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
